// File: src/radio_packet_event_controller_macros.svh
// ------------------------------------------------------------------------
// Radio packet event controller assertion macros
// Shared concurrent assertion forms used by the port checker.
// ------------------------------------------------------------------------
`ifndef RADIO_PACKET_EVENT_CONTROLLER_MACROS_SVH
`define RADIO_PACKET_EVENT_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPEC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radio packet event controller: check failed");

// The consequent must hold in the cycle after the antecedent.
`define RPEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radio packet event controller: check failed");

`endif

// File: src/rpec_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Radio packet event controller package
// Transaction types, register indexes, state codes and channel tables.
// ------------------------------------------------------------------------
package rpec_pkg;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_START_RX   = 3'd0;
  localparam logic [2:0] OP_DISPATCH   = 3'd1;
  localparam logic [2:0] OP_EVENTS     = 3'd2;
  localparam logic [2:0] OP_DISABLE    = 3'd3;
  localparam logic [2:0] OP_SET_CHAN   = 3'd4;
  localparam logic [2:0] OP_TAKE_PKT   = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PHY_MODE     = 2'd0;
  localparam logic [1:0] CFG_START_REPORT = 2'd1;
  localparam logic [1:0] CFG_END_REPORT   = 2'd2;

  // Radio state bits.
  localparam logic [2:0] ST_IDLE = 3'h0;
  localparam logic [2:0] ST_RX   = 3'h1;
  localparam logic [2:0] ST_TX   = 3'h2;
  localparam logic [2:0] ST_BUSY = 3'h4;

  // PHY mode that uses the 802.15.4 channel plan.
  localparam logic [2:0] PHY_IEEE154 = 3'd4;

  // Channel limits.
  localparam logic [7:0] BLE_CHAN_COUNT = 8'd40;
  localparam logic [7:0] IEEE_CHAN_MIN  = 8'd11;
  localparam logic [7:0] IEEE_CHAN_MAX  = 8'd26;
  localparam logic [4:0] IEEE_CHAN_BASE = 5'd10;

  typedef struct packed {
    logic [2:0]  op;
    logic        address_event;
    logic        end_event;
    logic        disabled_event;
    logic        crc_good;
    logic [31:0] time_now;
    logic [7:0]  channel_number;
  } in_t;

  typedef struct packed {
    logic [2:0]  radio_state;
    logic        start_report;
    logic        end_report;
    logic [31:0] report_time;
    logic        rx_pending;
    logic [31:0] crc_fail_count;
    logic [6:0]  freq_offset;
    logic        channel_bad;
    logic        refused;
  } out_t;

  typedef struct packed {
    logic [2:0] phy_mode;
    logic       start_report_enable;
    logic       end_report_enable;
  } cfg_t;

  // BLE channel index to frequency offset above 2400 MHz. Advertising
  // channels sit at the end of the index range.
  function automatic logic [6:0] ble_freq(input logic [5:0] ch);
    logic [6:0] f;
    begin
      case (ch)
        6'd0:  f = 7'd4;
        6'd1:  f = 7'd6;
        6'd2:  f = 7'd8;
        6'd3:  f = 7'd10;
        6'd4:  f = 7'd12;
        6'd5:  f = 7'd14;
        6'd6:  f = 7'd16;
        6'd7:  f = 7'd18;
        6'd8:  f = 7'd20;
        6'd9:  f = 7'd22;
        6'd10: f = 7'd24;
        6'd11: f = 7'd28;
        6'd12: f = 7'd30;
        6'd13: f = 7'd32;
        6'd14: f = 7'd34;
        6'd15: f = 7'd36;
        6'd16: f = 7'd38;
        6'd17: f = 7'd40;
        6'd18: f = 7'd42;
        6'd19: f = 7'd44;
        6'd20: f = 7'd46;
        6'd21: f = 7'd48;
        6'd22: f = 7'd50;
        6'd23: f = 7'd52;
        6'd24: f = 7'd54;
        6'd25: f = 7'd56;
        6'd26: f = 7'd58;
        6'd27: f = 7'd60;
        6'd28: f = 7'd62;
        6'd29: f = 7'd64;
        6'd30: f = 7'd66;
        6'd31: f = 7'd68;
        6'd32: f = 7'd70;
        6'd33: f = 7'd72;
        6'd34: f = 7'd74;
        6'd35: f = 7'd76;
        6'd36: f = 7'd78;
        6'd37: f = 7'd2;
        6'd38: f = 7'd26;
        6'd39: f = 7'd80;
        default: f = 7'd0;
      endcase
      return f;
    end
  endfunction

endpackage

// File: src/rpec_cfg_regs.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Radio packet event controller configuration registers
// Decodes write transactions on the configuration port into the settings.
// ------------------------------------------------------------------------
module rpec_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [2:0]         wr_data,
  output rpec_pkg::cfg_t     cfg
);

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        rpec_pkg::CFG_PHY_MODE:     cfg.phy_mode <= wr_data;
        rpec_pkg::CFG_START_REPORT: cfg.start_report_enable <= wr_data[0];
        rpec_pkg::CFG_END_REPORT:   cfg.end_report_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/rpec_core.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Radio packet event controller core
// Holds the radio state and computes the result of one command or event.
// ------------------------------------------------------------------------
module rpec_core (
  input  logic             clk,
  input  logic             rst,
  input  rpec_pkg::cfg_t   cfg,
  input  logic             step,
  input  rpec_pkg::in_t    item,
  output rpec_pkg::out_t   result
);

  logic [2:0]  mode_bits;
  logic [2:0]  mode_bits_next;
  logic        packet_waiting;
  logic        packet_waiting_next;
  logic [31:0] crc_fail_total;
  logic [31:0] crc_fail_total_next;
  logic [6:0]  current_freq;
  logic [6:0]  current_freq_next;

  logic [4:0]  ieee_offset;
  logic [6:0]  ieee_freq;

  // 802.15.4 frequency is five times the distance from channel ten.
  assign ieee_offset = item.channel_number[4:0] - rpec_pkg::IEEE_CHAN_BASE;
  assign ieee_freq   = {ieee_offset, 2'b00} + {2'b00, ieee_offset};

  // Next state and result for the item in the input register.
  always_comb begin
    logic       rep_start;
    logic       rep_end;
    logic       bad;
    logic       refuse;
    logic [2:0] m;
    rep_start           = 1'b0;
    rep_end             = 1'b0;
    bad                 = 1'b0;
    refuse              = 1'b0;
    m                   = mode_bits;
    packet_waiting_next = packet_waiting;
    crc_fail_total_next = crc_fail_total;
    current_freq_next   = current_freq;

    case (item.op)
      rpec_pkg::OP_START_RX, rpec_pkg::OP_DISPATCH: begin
        if (mode_bits != rpec_pkg::ST_IDLE) begin
          refuse = 1'b1;
        end else if (item.op == rpec_pkg::OP_START_RX) begin
          m = rpec_pkg::ST_RX;
        end else begin
          m = rpec_pkg::ST_TX;
        end
      end
      rpec_pkg::OP_EVENTS: begin
        // Address, end and disabled are handled in that order.
        if (item.address_event) begin
          m = m | rpec_pkg::ST_BUSY;
          rep_start = cfg.start_report_enable;
        end
        if (item.end_event) begin
          if (m == (rpec_pkg::ST_BUSY | rpec_pkg::ST_RX)) begin
            if (!item.crc_good) begin
              crc_fail_total_next = crc_fail_total + 32'd1;
            end else if (cfg.end_report_enable) begin
              packet_waiting_next = 1'b1;
              rep_end = 1'b1;
            end
          end else if (m == (rpec_pkg::ST_BUSY | rpec_pkg::ST_TX)) begin
            rep_end = cfg.end_report_enable;
          end
        end
        if (item.disabled_event) begin
          m = rpec_pkg::ST_IDLE;
        end
      end
      rpec_pkg::OP_DISABLE: begin
        m = rpec_pkg::ST_IDLE;
      end
      rpec_pkg::OP_SET_CHAN: begin
        if (cfg.phy_mode == rpec_pkg::PHY_IEEE154) begin
          if (item.channel_number >= rpec_pkg::IEEE_CHAN_MIN &&
              item.channel_number <= rpec_pkg::IEEE_CHAN_MAX) begin
            current_freq_next = ieee_freq;
          end else begin
            bad = 1'b1;
          end
        end else begin
          if (item.channel_number < rpec_pkg::BLE_CHAN_COUNT) begin
            current_freq_next = rpec_pkg::ble_freq(item.channel_number[5:0]);
          end else begin
            bad = 1'b1;
          end
        end
      end
      rpec_pkg::OP_TAKE_PKT: begin
        packet_waiting_next = 1'b0;
      end
      default: ;
    endcase

    mode_bits_next        = m;
    result.radio_state    = m;
    result.start_report   = rep_start;
    result.end_report     = rep_end;
    result.report_time    = (rep_start || rep_end) ? item.time_now : 32'd0;
    result.rx_pending     = packet_waiting_next;
    result.crc_fail_count = crc_fail_total_next;
    result.freq_offset    = current_freq_next;
    result.channel_bad    = bad;
    result.refused        = refuse;
  end

  // State registers advance once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits      <= rpec_pkg::ST_IDLE;
      packet_waiting <= 1'b0;
      crc_fail_total <= 32'd0;
      current_freq   <= 7'd0;
    end else if (step) begin
      mode_bits      <= mode_bits_next;
      packet_waiting <= packet_waiting_next;
      crc_fail_total <= crc_fail_total_next;
      current_freq   <= current_freq_next;
    end
  end

endmodule

// File: src/radio_packet_event_controller.sv
`timescale 1ns / 1ps
// An accepted transaction is held in the input register, and its result is then
// held in the result register. Throughput: one transaction per cycle; the input
// register feeds the state update logic and the result register, and both advance
// together whenever the result register is empty or being drained.
// Reset: synchronous, active high; clears the radio state, counters, settings
// and both valid flags.
// ------------------------------------------------------------------------
// Radio packet event controller
// Tracks the packet radio state, reports packet start and end, counts CRC
// failures and maps channel numbers to frequency offsets.
// ------------------------------------------------------------------------
module radio_packet_event_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rpec_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rpec_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [2:0]       cfg_data
);

  rpec_pkg::cfg_t cfg;
  rpec_pkg::in_t  stage_data;
  rpec_pkg::out_t core_result;
  logic           stage_valid;
  logic           advance;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  rpec_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The input register moves into the result register when that is free.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_data <= in_data;
    end
  end

  rpec_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (stage_data),
    .result (core_result)
  );

  // Result register holds until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

endmodule

// File: src/rpec_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Radio packet event controller port checker
// Watches the top-level ports for consistency of result transactions.
// ------------------------------------------------------------------------
`include "radio_packet_event_controller_macros.svh"

module rpec_checker (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input rpec_pkg::out_t   out_data
);

  // A stalled result stays put.
  `RPEC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(out_data))

  // The timestamp is only carried with a report.
  `RPEC_ASSERT_NOW(a_time_zero, clk, rst,
                   out_valid && !out_data.start_report && !out_data.end_report,
                   out_data.report_time == 32'd0)

  // A refused start is a command, never an event step with reports.
  `RPEC_ASSERT_NOW(a_refuse_alone, clk, rst, out_valid && out_data.refused,
                   !out_data.start_report && !out_data.end_report && !out_data.channel_bad)

  // A rejected channel comes from a channel command only.
  `RPEC_ASSERT_NOW(a_bad_alone, clk, rst, out_valid && out_data.channel_bad,
                   !out_data.start_report && !out_data.end_report && !out_data.refused)

endmodule

bind radio_packet_event_controller rpec_checker u_rpec_checker (.*);
